// File: rtl/vbct_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vbct_pkg;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 8'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 8'd3;

	// Request kinds carried by req_type.
	localparam logic REQ_WRITE  = 1'b0;
	localparam logic REQ_SAMPLE = 1'b1;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_TEX,
		ST_PAL
	} seq_state_t;

	// Status of the blit cursor for the next write word.
	typedef struct packed {
		logic active;
		logic in_mem;
	} blit_wr_t;

endpackage

`default_nettype wire

// File: rtl/vbct_vram.sv
`timescale 1ns / 1ps
`default_nettype none

module vbct_vram #(
	parameter int DEPTH = 524288,
	parameter int AW    = 19
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic          we,
	input  wire logic [AW-1:0] addr,
	input  wire logic [15:0]   wdata,
	output logic      [15:0]   rdata
);

	logic [15:0] mem [DEPTH];
	logic [15:0] rdata_q;

	// Single port: one write or one registered read per cycle.
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata_q <= mem[addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// File: rtl/vbct_blit.sv
`timescale 1ns / 1ps
`default_nettype none

module vbct_blit
	import vbct_pkg::*;
#(
	parameter int MEM_COLS = 1024,
	parameter int MEM_ROWS = 512,
	parameter int AW       = 19
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_write,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [15:0]          cfg_data,
	input  wire logic                 advance,
	output blit_wr_t                  wr_status,
	output logic      [AW-1:0]        wr_addr
);

	logic [15:0] origin_x_q;
	logic [15:0] origin_y_q;
	logic [15:0] width_q;
	logic [15:0] height_q;
	logic [15:0] col_q;
	logic [16:0] row_q;

	logic signed [17:0] dx;
	logic signed [18:0] dy;
	logic        [16:0] col_inc;

	// Register writes; any valid index returns the cursor to the corner.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			width_q    <= '0;
			height_q   <= '0;
			col_q      <= '0;
			row_q      <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_ORIGIN_X: begin
					origin_x_q <= cfg_data;
					col_q      <= '0;
					row_q      <= '0;
				end
				CFG_ORIGIN_Y: begin
					origin_y_q <= cfg_data;
					col_q      <= '0;
					row_q      <= '0;
				end
				CFG_WIDTH: begin
					width_q <= cfg_data;
					col_q   <= '0;
					row_q   <= '0;
				end
				CFG_HEIGHT: begin
					height_q <= cfg_data;
					col_q    <= '0;
					row_q    <= '0;
				end
				default: begin
				end
			endcase
		end else if (advance) begin
			// Step across the row, wrapping to the next row at the width.
			if (col_inc >= {1'b0, width_q}) begin
				col_q <= '0;
				row_q <= row_q + 17'd1;
			end else begin
				col_q <= col_inc[15:0];
			end
		end
	end

	assign col_inc = {1'b0, col_q} + 17'd1;

	// Target position of the next word in memory coordinates.
	assign dx = $signed({{2{origin_x_q[15]}}, origin_x_q}) + $signed({2'b00, col_q});
	assign dy = $signed({{3{origin_y_q[15]}}, origin_y_q}) + $signed({2'b00, row_q});

	assign wr_status.active = (width_q != 16'd0) && (row_q < {1'b0, height_q});
	assign wr_status.in_mem = !dx[17] && (32'(dx[16:0]) < 32'(MEM_COLS))
		&& !dy[18] && (32'(dy[17:0]) < 32'(MEM_ROWS));

	assign wr_addr = AW'(32'(dy[17:0]) * 32'(MEM_COLS) + 32'(dx[16:0]));

endmodule

`default_nettype wire

// File: rtl/vbct_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module vbct_ctrl
	import vbct_pkg::*;
#(
	parameter int MEM_COLS = 1024,
	parameter int MEM_ROWS = 512,
	parameter int DEPTH    = 524288,
	parameter int AW       = 19
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire logic          req_type,
	input  wire logic [15:0]   wr_data,
	input  wire logic [4:0]    tex_page,
	input  wire logic [14:0]   palette_word,
	input  wire logic [7:0]    tex_u,
	input  wire logic [7:0]    tex_v,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output logic      [31:0]   texel_rgba,
	input  wire blit_wr_t      blit_wr,
	input  wire logic [AW-1:0] blit_addr,
	output logic               blit_advance,
	output logic               mem_en,
	output logic               mem_we,
	output logic      [AW-1:0] mem_addr,
	output logic      [15:0]   mem_wdata,
	input  wire logic [15:0]   mem_rdata,
	output seq_state_t         seq_state
);

	seq_state_t state_q;
	seq_state_t state_d;

	logic [AW-1:0] clr_q;
	logic          clr_last;

	logic          take_req;
	logic          out_free;
	logic          out_load;
	logic          out_valid_q;
	logic [31:0]   texel_q;

	logic [9:0]    tex_hx;
	logic [8:0]    tex_hy;
	logic          tex_in_mem;
	logic [AW-1:0] tex_addr;

	logic [14:0]   pal_word_s1;
	logic [1:0]    u_lo_s1;
	logic          tex_ok_s1;
	logic          pal_ok_s2;

	logic [3:0]    idx;
	logic [9:0]    pal_x;
	logic [8:0]    pal_y;
	logic          pal_in_mem;
	logic [AW-1:0] pal_addr;

	// Expand a 15-bit colour to 8 bits a channel; zero means transparent.
	function automatic logic [31:0] clut_rgba(input logic [15:0] c);
		logic [4:0] r;
		logic [4:0] g;
		logic [4:0] b;
		r = c[4:0];
		g = c[9:5];
		b = c[14:10];
		if (c == 16'h0000) begin
			return 32'h0000_0000;
		end
		return {8'hFF, b, b[4:2], g, g[4:2], r, r[4:2]};
	endfunction

	// Halfword that packs the requested texel.
	assign tex_hx     = {tex_page[3:0], tex_u[7:2]};
	assign tex_hy     = {tex_page[4], tex_v};
	assign tex_in_mem = (32'(tex_hx) < 32'(MEM_COLS)) && (32'(tex_hy) < 32'(MEM_ROWS));
	assign tex_addr   = AW'(32'(tex_hy) * 32'(MEM_COLS) + 32'(tex_hx));

	// Palette entry selected by the texel index.
	assign idx        = 4'(mem_rdata >> {u_lo_s1, 2'b00});
	assign pal_x      = {pal_word_s1[5:0], idx};
	assign pal_y      = pal_word_s1[14:6];
	assign pal_in_mem = (32'(pal_x) < 32'(MEM_COLS)) && (32'(pal_y) < 32'(MEM_ROWS));
	assign pal_addr   = AW'(32'(pal_y) * 32'(MEM_COLS) + 32'(pal_x));

	assign clr_last = (clr_q == AW'(DEPTH - 1));
	assign out_free = !out_valid_q || !rsp_stall;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, memory port and handshake.
	always_comb begin
		state_d      = state_q;
		take_req     = 1'b0;
		out_load     = 1'b0;
		mem_en       = 1'b0;
		mem_we       = 1'b0;
		mem_addr     = tex_addr;
		mem_wdata    = wr_data;
		blit_advance = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				mem_en    = 1'b1;
				mem_we    = 1'b1;
				mem_addr  = clr_q;
				mem_wdata = '0;
				if (clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				take_req = 1'b1;
			end
			ST_TEX: begin
				mem_en   = tex_ok_s1 && pal_in_mem;
				mem_addr = pal_addr;
				state_d  = ST_PAL;
			end
			ST_PAL: begin
				if (out_free) begin
					out_load = 1'b1;
					take_req = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
		if (take_req && req_valid) begin
			if (req_type == REQ_SAMPLE) begin
				mem_en   = tex_in_mem;
				mem_addr = tex_addr;
				state_d  = ST_TEX;
			end else begin
				mem_en       = blit_wr.active && blit_wr.in_mem;
				mem_we       = blit_wr.active && blit_wr.in_mem;
				mem_addr     = blit_addr;
				blit_advance = blit_wr.active;
			end
		end
	end

	assign req_stall = !take_req;

	// Clearing pass address.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (state_q == ST_CLEAR) begin
			clr_q <= clr_q + AW'(1);
		end
	end

	// Sample context carried to the palette read.
	always_ff @(posedge clk) begin
		if (take_req && req_valid && (req_type == REQ_SAMPLE)) begin
			pal_word_s1 <= palette_word;
			u_lo_s1     <= tex_u[1:0];
			tex_ok_s1   <= tex_in_mem;
		end
		if (state_q == ST_TEX) begin
			pal_ok_s2 <= tex_ok_s1 && pal_in_mem;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			texel_q <= pal_ok_s2 ? clut_rgba(mem_rdata) : 32'h0000_0000;
		end
	end

	assign rsp_valid  = out_valid_q;
	assign texel_rgba = texel_q;
	assign seq_state  = state_q;

endmodule

`default_nettype wire

// File: rtl/vram_blit_and_clut4_texel_sample.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Handshake            Payload
// req      req_valid/req_stall  req_type, wr_data, tex_page, palette_word, tex_u, tex_v
// rsp      rsp_valid/rsp_stall  texel_rgba (one word per sample, none per write)
// cfg      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A write word goes to memory in the cycle it is taken; a sample makes two dependent
// reads (packed texel, then palette entry) on the single port of the video memory.
// After reset the memory is swept to zero, one halfword a cycle, over all
// MEM_COLS * MEM_ROWS halfwords (524288 at the defaults); req_stall stays high until it ends.
// A finished sample waits in the output register; new words are taken while it waits,
// and only the next sample's final step holds until rsp_stall drops.
module vram_blit_and_clut4_texel_sample
	import vbct_pkg::*;
#(
	parameter int MEM_COLS = 1024,
	parameter int MEM_ROWS = 512
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 req_valid,
	output logic                      req_stall,
	input  wire logic                 req_type,
	input  wire logic [15:0]          wr_data,
	input  wire logic [4:0]           tex_page,
	input  wire logic [14:0]          palette_word,
	input  wire logic [7:0]           tex_u,
	input  wire logic [7:0]           tex_v,
	output logic                      rsp_valid,
	input  wire logic                 rsp_stall,
	output logic      [31:0]          texel_rgba,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [15:0]          cfg_data
);

	localparam int DEPTH = MEM_COLS * MEM_ROWS;
	localparam int AW    = $clog2(DEPTH);

	blit_wr_t      blit_wr;
	logic [AW-1:0] blit_addr;
	logic          blit_advance;
	logic          mem_en;
	logic          mem_we;
	logic [AW-1:0] mem_addr;
	logic [15:0]   mem_wdata;
	logic [15:0]   mem_rdata;
	seq_state_t    seq_state;

	// Registers are always writable.
	assign cfg_ready = 1'b1;

	vbct_blit #(
		.MEM_COLS (MEM_COLS),
		.MEM_ROWS (MEM_ROWS),
		.AW       (AW)
	) u_blit (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.advance   (blit_advance),
		.wr_status (blit_wr),
		.wr_addr   (blit_addr)
	);

	vbct_ctrl #(
		.MEM_COLS (MEM_COLS),
		.MEM_ROWS (MEM_ROWS),
		.DEPTH    (DEPTH),
		.AW       (AW)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.req_type     (req_type),
		.wr_data      (wr_data),
		.tex_page     (tex_page),
		.palette_word (palette_word),
		.tex_u        (tex_u),
		.tex_v        (tex_v),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.texel_rgba   (texel_rgba),
		.blit_wr      (blit_wr),
		.blit_addr    (blit_addr),
		.blit_advance (blit_advance),
		.mem_en       (mem_en),
		.mem_we       (mem_we),
		.mem_addr     (mem_addr),
		.mem_wdata    (mem_wdata),
		.mem_rdata    (mem_rdata),
		.seq_state    (seq_state)
	);

	vbct_vram #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_vram (
		.clk   (clk),
		.en    (mem_en),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	// No word is taken while the memory is being cleared.
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(seq_state == ST_CLEAR) |-> req_stall)
		else $error("request taken during clearing pass");

	// An accepted sample starts its texel read.
	a_sample_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall && (req_type == REQ_SAMPLE)) |=> (seq_state == ST_TEX))
		else $error("sample did not enter texel read");

	// The palette read always follows the texel read.
	a_tex_to_pal: assert property (@(posedge clk) disable iff (!arst_n)
		(seq_state == ST_TEX) |=> (seq_state == ST_PAL))
		else $error("palette read did not follow texel read");

	// A result only appears at the end of a sample.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> ($past(seq_state) == ST_PAL))
		else $error("result word without a finished sample");

endmodule

`default_nettype wire
